// ----- design/vpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpf_pkg
// Shared types and constants for the vertex projection and fog pipeline.
// ----------------------------------------------------------------------------
package vpf_pkg;

   localparam int FracBits   = 16;
   localparam int CoordWidth = 32;
   localparam int DimWidth   = 14;
   localparam int FogWidth   = 31;
   localparam int BrightWidth = 17;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 31;

   // numerator |c| * dim, divided by z with FracBits-1 extra quotient bits
   localparam int NumWidth   = CoordWidth + DimWidth;
   localparam int QuotWidth  = NumWidth + FracBits - 1;
   localparam int CapBits    = 50;
   localparam int RemWidth   = CoordWidth + 1;

   // sum of squares of three 32-bit magnitudes
   localparam int SqWidth    = 64;
   localparam int RootWidth  = 32;
   localparam int DropWidth  = 48;

   localparam logic [CoordWidth-1:0] ZMinQ =
      CoordWidth'((((64'd1 << FracBits) + 64'd500) / 64'd1000) > 0 ?
                  (((64'd1 << FracBits) + 64'd500) / 64'd1000) : 64'd1);

   localparam logic [BrightWidth-1:0] BrightOne = BrightWidth'(65536);

   localparam logic [CsrIdxWidth-1:0] RegWidth  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegHeight = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegFogSt  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] RegFogEnd = 2'd3;

   typedef struct packed {
      logic signed [CoordWidth-1:0] vertex_x;
      logic signed [CoordWidth-1:0] vertex_y;
      logic signed [CoordWidth-1:0] vertex_z;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] screen_x;
      logic signed [CoordWidth-1:0] screen_y;
      logic [BrightWidth-1:0]       brightness;
      logic                         saturated;
   } rsp_type;

endpackage

// ----- design/vertex_project_fog.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_fog
// Perspective divide, viewport mapping and linear fog, one vertex per cycle while not stalled.
// ----------------------------------------------------------------------------
//  channel | ports           | word
//  req     | req_valid/stall | vertex_x, vertex_y, vertex_z
//  rsp     | rsp_valid/stall | screen_x, screen_y, brightness, saturated
//  csr     | csr_we/idx/data | screen_width, screen_height, fog_start, fog_end
//
// One vertex enters per cycle while the pipeline advances; the stages are
// entry, squares, 61 divide stages, saturation and 19 fog stages. Reset
// clears valid bits and loads register defaults. A stall on rsp while
// rsp_valid is high freezes the whole pipeline; req_stall follows it.
// ----------------------------------------------------------------------------
module vertex_project_fog (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  vpf_pkg::req_type                 req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output vpf_pkg::rsp_type                 rsp_word,
   input  logic                             csr_we,
   input  logic [vpf_pkg::CsrIdxWidth-1:0]  csr_idx,
   input  logic [vpf_pkg::CsrDataWidth-1:0] csr_data
);
   import vpf_pkg::*;

   logic [DimWidth-1:0] width_ff, height_ff;
   logic [FogWidth-1:0] fog_start_ff, fog_end_ff;
   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DimWidth'(640);
         height_ff    <= DimWidth'(480);
         fog_start_ff <= '0;
         fog_end_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            RegWidth:  width_ff     <= csr_data[DimWidth-1:0];
            RegHeight: height_ff    <= csr_data[DimWidth-1:0];
            RegFogSt:  fog_start_ff <= csr_data[FogWidth-1:0];
            RegFogEnd: fog_end_ff   <= csr_data[FogWidth-1:0];
            default: ;
         endcase
      end
   end

   // hold everything while the output word waits
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   vpf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .width     (width_ff),
      .height    (height_ff),
      .fog_start (fog_start_ff),
      .fog_end   (fog_end_ff),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule

// ----- design/vpf_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpf_core
// Stall-capable datapath: clamp, scale, restoring divides and square root
// unrolled one bit per stage, fog ramp and saturation.
// ----------------------------------------------------------------------------
module vpf_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  vpf_pkg::req_type             in_word,
   input  logic [vpf_pkg::DimWidth-1:0] width,
   input  logic [vpf_pkg::DimWidth-1:0] height,
   input  logic [vpf_pkg::FogWidth-1:0] fog_start,
   input  logic [vpf_pkg::FogWidth-1:0] fog_end,
   output logic                         out_valid,
   output vpf_pkg::rsp_type             out_word
);
   import vpf_pkg::*;

   localparam int QSteps = QuotWidth;        // quotient bits of coordinate divide
   localparam int RSteps = RootWidth;        // root bits
   localparam int DSteps = BrightWidth + 1;  // fog ramp quotient bits
   localparam int Depth  = 2 + QSteps + 2 + DSteps;

   typedef struct packed {
      logic [NumWidth-1:0]  nx;
      logic [NumWidth-1:0]  ny;
      logic [RemWidth-1:0]  rx;
      logic [RemWidth-1:0]  ry;
      logic [QuotWidth-1:0] qx;
      logic [QuotWidth-1:0] qy;
      logic [CoordWidth-1:0] zc;
      logic                 negx;
      logic                 negy;
      logic [CoordWidth+FracBits:0] offx;
      logic [CoordWidth+FracBits:0] offy;
      logic [SqWidth-1:0]   sq;
      logic [SqWidth-1:0]   rrem;
      logic [RootWidth-1:0] root;
      logic                 far;
      logic                 fog_on;
      logic [FogWidth-1:0]  fst;
      logic [FogWidth-1:0]  frange;
      logic [DropWidth-1:0] dnum;
      logic [FogWidth:0]    drem;
      logic [DSteps-1:0]    dq;
      logic                 nofog;
   } work_type;

   work_type         st_ff [Depth];
   logic [Depth-1:0] vld_ff;

   // stage 0: magnitudes, clamp, products
   work_type s0;
   logic [CoordWidth-1:0] ax, ay, az;
   always_comb begin
      s0 = '0;
      ax = in_word.vertex_x[CoordWidth-1] ? CoordWidth'(-in_word.vertex_x)
                                          : in_word.vertex_x;
      ay = in_word.vertex_y[CoordWidth-1] ? CoordWidth'(-in_word.vertex_y)
                                          : in_word.vertex_y;
      az = in_word.vertex_z[CoordWidth-1] ? CoordWidth'(-in_word.vertex_z)
                                          : in_word.vertex_z;
      s0.nx = NumWidth'(ax) * NumWidth'(width);
      s0.ny = NumWidth'(ay) * NumWidth'(height);
      s0.zc = ($signed(in_word.vertex_z) <= $signed(ZMinQ)) ? ZMinQ
                                                           : in_word.vertex_z;
      s0.negx = in_word.vertex_x[CoordWidth-1];
      s0.negy = in_word.vertex_y[CoordWidth-1];
      s0.offx = (CoordWidth+FracBits+1)'(width) << (FracBits - 1);
      s0.offy = (CoordWidth+FracBits+1)'(height) << (FracBits - 1);
      s0.far = ax[CoordWidth-1] | ay[CoordWidth-1] | az[CoordWidth-1];
      s0.sq = SqWidth'(ax) * SqWidth'(ax);
      s0.rrem = SqWidth'(ay);
      s0.root = az;
      s0.fog_on = fog_end > fog_start;
      s0.fst = fog_start;
      s0.frange = fog_end - fog_start;
   end

   // stage 1: finish sum of squares
   function automatic work_type sq_step(work_type w);
      work_type o;
      o = w;
      o.sq = w.sq + SqWidth'(w.rrem[RootWidth-1:0]) * SqWidth'(w.rrem[RootWidth-1:0])
             + SqWidth'(w.root) * SqWidth'(w.root);
      o.rrem = '0;
      o.root = '0;
      o.rx = '0;
      o.ry = '0;
      o.qx = '0;
      o.qy = '0;
      return o;
   endfunction

   // one quotient bit per stage for both coordinates, plus one root bit in the first RSteps stages
   function automatic work_type div_step(work_type w, int k);
      work_type o;
      logic [RemWidth:0] tx, ty;
      logic [SqWidth+1:0] trial;
      int nb;
      int sb;
      o = w;
      nb = QSteps - 1 - k;
      tx = {w.rx, (nb >= FracBits - 1) ? w.nx[nb-(FracBits-1)] : 1'b0};
      ty = {w.ry, (nb >= FracBits - 1) ? w.ny[nb-(FracBits-1)] : 1'b0};
      if (tx >= (RemWidth+1)'(w.zc)) begin
         o.rx = RemWidth'(tx - (RemWidth+1)'(w.zc));
         o.qx = {w.qx[QuotWidth-2:0], 1'b1};
      end else begin
         o.rx = RemWidth'(tx);
         o.qx = {w.qx[QuotWidth-2:0], 1'b0};
      end
      if (ty >= (RemWidth+1)'(w.zc)) begin
         o.ry = RemWidth'(ty - (RemWidth+1)'(w.zc));
         o.qy = {w.qy[QuotWidth-2:0], 1'b1};
      end else begin
         o.ry = RemWidth'(ty);
         o.qy = {w.qy[QuotWidth-2:0], 1'b0};
      end
      // digit-by-digit root: two radicand bits per bit of result
      if (k < RSteps) begin
         sb = 2 * (RSteps - 1 - k);
         trial = {w.rrem, w.sq[sb+1], w.sq[sb]};
         if (trial >= {w.root, 2'b01}) begin
            o.rrem = SqWidth'(trial - {w.root, 2'b01});
            o.root = {w.root[RootWidth-2:0], 1'b1};
         end else begin
            o.rrem = SqWidth'(trial);
            o.root = {w.root[RootWidth-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   // screen coordinates with saturation; fog numerator
   function automatic work_type post_step(work_type w);
      work_type o;
      logic [QuotWidth:0] cx, cy;
      logic signed [QuotWidth+2:0] vx, vy;
      logic signed [QuotWidth+2:0] cmax, cmin;
      logic sx, sy;
      o = w;
      cx = (w.qx >= QuotWidth'(64'd1 << CapBits)) ?
           (QuotWidth+1)'(64'd1 << CapBits) : (QuotWidth+1)'(w.qx);
      cy = (w.qy >= QuotWidth'(64'd1 << CapBits)) ?
           (QuotWidth+1)'(64'd1 << CapBits) : (QuotWidth+1)'(w.qy);
      vx = w.negx ? $signed((QuotWidth+3)'(w.offx)) - $signed((QuotWidth+3)'(cx))
                  : $signed((QuotWidth+3)'(w.offx)) + $signed((QuotWidth+3)'(cx));
      vy = w.negy ? $signed((QuotWidth+3)'(w.offy)) + $signed((QuotWidth+3)'(cy))
                  : $signed((QuotWidth+3)'(w.offy)) - $signed((QuotWidth+3)'(cy));
      cmax = (QuotWidth+3)'((64'd1 << (CoordWidth-1)) - 64'd1);
      cmin = -(QuotWidth+3)'(64'd1 << (CoordWidth-1));
      sx = 1'b0;
      sy = 1'b0;
      if (vx > cmax) begin vx = cmax; sx = 1'b1; end
      else if (vx < cmin) begin vx = cmin; sx = 1'b1; end
      if (vy > cmax) begin vy = cmax; sy = 1'b1; end
      else if (vy < cmin) begin vy = cmin; sy = 1'b1; end
      o.qx = QuotWidth'(vx);
      o.qy = QuotWidth'(vy);
      o.negx = sx | sy;
      o.nofog = !w.fog_on || (!w.far && (RootWidth+1)'(w.root) < (RootWidth+1)'(w.fst));
      o.dnum = DropWidth'(w.root - RootWidth'(w.fst)) << 16;
      o.drem = '0;
      o.dq = '0;
      return o;
   endfunction

   // fog ramp divide, one bit per stage
   function automatic work_type fog_step(work_type w);
      work_type o;
      logic [FogWidth+1:0] t;
      o = w;
      t = {w.drem, w.dnum[DropWidth-1]};
      o.dnum = w.dnum << 1;
      if (t >= (FogWidth+2)'(w.frange)) begin
         o.drem = (FogWidth+1)'(t - (FogWidth+2)'(w.frange));
         o.dq = {w.dq[DSteps-2:0], 1'b1};
      end else begin
         o.drem = (FogWidth+1)'(t);
         o.dq = {w.dq[DSteps-2:0], 1'b0};
      end
      return o;
   endfunction

   // stage map: 0 entry, 1 squares, 2..QSteps+1 divide, +1 post, then fog
   localparam int DivBase  = 2;
   localparam int PostIdx  = DivBase + QSteps;
   localparam int FogBase  = PostIdx + 1;
   localparam int FogPre   = DropWidth - DSteps;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], in_valid};
      end
   end

   // leading fog numerator bits take one compare: if they reach the range (quotient
   // far past full scale) mark full fog; they become the remainder in both cases
   function automatic work_type fog_pre(work_type w);
      work_type o;
      o = w;
      if ((FogWidth+1)'(w.dnum[DropWidth-1:DSteps]) >= (FogWidth+1)'(w.frange))
         o.far = 1'b1;
      o.drem = (FogWidth+1)'(w.dnum[DropWidth-1:DSteps]);
      o.dnum = w.dnum << FogPre;
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= s0;
         st_ff[1] <= sq_step(st_ff[0]);
         for (int k = 0; k < QSteps; k++)
            st_ff[DivBase+k] <= div_step(st_ff[DivBase+k-1], k);
         st_ff[PostIdx] <= post_step(st_ff[PostIdx-1]);
         st_ff[FogBase] <= fog_pre(st_ff[PostIdx]);
         for (int k = 1; k < Depth - FogBase; k++)
            st_ff[FogBase+k] <= fog_step(st_ff[FogBase+k-1]);
      end
   end

   work_type last;
   always_comb begin
      last = st_ff[Depth-1];
      out_valid = vld_ff[Depth-1];
      out_word.screen_x = CoordWidth'(last.qx);
      out_word.screen_y = CoordWidth'(last.qy);
      out_word.saturated = last.negx;
      if (last.nofog)
         out_word.brightness = BrightOne;
      else if (last.far || (DSteps+1)'(last.dq) >= (DSteps+1)'(BrightOne))
         out_word.brightness = '0;
      else
         out_word.brightness = BrightOne - BrightWidth'(last.dq);
   end

endmodule
